// ----- sv/sorted_deadline_timer_queue_defines.svh -----
// Assertion macros for the sorted deadline timer queue.
// Included by the top level; no other dependencies.
`ifndef SORTED_DEADLINE_TIMER_QUEUE_DEFINES_SVH
`define SORTED_DEADLINE_TIMER_QUEUE_DEFINES_SVH

// Assert that an implication holds on every clock edge out of reset.
`define SDTQ_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Assert that a signal holds while it is stalled.
`define SDTQ_HOLD(label, clk, rst_n, vld, rdy, sig, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (vld && !rdy) |=> $stable(sig)) else $error(msg);

`endif

// ----- sv/sdtq_pkg.sv -----
// Types and constants shared by the sorted deadline timer queue.
// No dependencies.
package sdtq_pkg;

    typedef enum logic [1:0] {
        REQ_TICK   = 2'd0,
        REQ_ARM    = 2'd1,
        REQ_CANCEL = 2'd2,
        REQ_NONE   = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        KIND_ARMED  = 2'd0,
        KIND_FULL   = 2'd1,
        KIND_CANCEL = 2'd2,
        KIND_EXPIRY = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ARM_SCAN,
        ST_ARM_SHIFT,
        ST_CAN_SCAN,
        ST_CAN_SHIFT,
        ST_TICK_COUNT,
        ST_TICK_CHECK,
        ST_TICK_POP,
        ST_TICK_EMIT,
        ST_REINS_SCAN,
        ST_REINS_SHIFT,
        ST_OUT
    } state_t;

    localparam int MAX_RESULTS = 32;

endpackage

// ----- sv/sdtq_slot_mem.sv -----
// Slot storage of the timer queue: one wide register file, one write and
// one read port, registered read data. Uses nothing from the package.
module sdtq_slot_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 96
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write and read in the same clocked block; read sees old data
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

// ----- sv/sorted_deadline_timer_queue.sv -----
// Sorted deadline timer queue, top level: sequencer, shared compare unit
// and slot memory. Depends on sdtq_pkg, sdtq_slot_mem and the defines header.
//
// The queue holds up to DEPTH timers in a slot memory sorted by wrap-aware
// distance of the deadline from the tick count. A request is worked by one
// sequencer through a single compare/add unit and the memory's one read and
// one write port. An arm with room scans for its place, moves the later
// slots up and writes the entry; a cancel scans for the instance and moves
// the later slots down. A tick first counts the due timers, then for each
// one removes and emits it and puts a repeating timer back. Each result
// waits in an output register until taken; s_tready is low while a request
// is in work or a result waits, so output stalls add directly to the time
// per request. Slot contents are undefined after reset; only occupied slots
// are read, so no clearing pass is needed.
`include "sorted_deadline_timer_queue_defines.svh"
module sorted_deadline_timer_queue #(
    parameter int DEPTH          = 16,
    parameter int COUNT_WIDTH    = 32,
    parameter int INSTANCE_WIDTH = 8,
    parameter int HANDLE_WIDTH   = 8,
    parameter int ARG_WIDTH      = 16
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    // deadline, repeat_period, target_handle, user_argument, cancel_id
    input  logic [((2*COUNT_WIDTH+HANDLE_WIDTH+ARG_WIDTH+INSTANCE_WIDTH+7)/8)*8-1:0] s_tdata,
    // req_type
    input  logic [1:0] s_tuser,
    output logic m_tvalid,
    input  logic m_tready,
    // instance_id, notify_handle, notify_argument, was_found, current_count
    output logic [((INSTANCE_WIDTH+HANDLE_WIDTH+ARG_WIDTH+1+COUNT_WIDTH+7)/8)*8-1:0] m_tdata,
    // result_kind
    output logic [1:0] m_tuser,
    output logic m_tlast
);
    import sdtq_pkg::*;

    localparam int AW  = $clog2(DEPTH);
    localparam int NW  = $clog2(DEPTH+1);
    localparam int CW  = COUNT_WIDTH;
    localparam int IW  = INSTANCE_WIDTH;
    localparam int HW  = HANDLE_WIDTH;
    localparam int GW  = ARG_WIDTH;
    localparam int EW  = 2*CW+HW+IW+GW;
    localparam int SIW = 2*CW+HW+GW+IW;
    localparam int SOW = IW+HW+GW+1+CW;
    localparam int RW  = $clog2(MAX_RESULTS+1);

    // Entry layout: deadline, period, handle, instance, argument (low first)
    function automatic logic [EW-1:0] pack_e(logic [CW-1:0] d, logic [CW-1:0] p,
        logic [HW-1:0] h, logic [IW-1:0] i, logic [GW-1:0] g);
        pack_e = {g, i, h, p, d};
    endfunction

    state_t state_reg, state_next;
    logic [CW-1:0] now_reg, now_next;
    logic [NW-1:0] occ_reg, occ_next;
    logic [IW-1:0] last_reg, last_next;
    logic [NW-1:0] idx_reg, idx_next;
    logic [NW-1:0] pos_reg, pos_next;
    logic [RW-1:0] fired_reg, fired_next;
    logic [RW-1:0] due_reg, due_next;
    logic [EW-1:0] ent_reg, ent_next;
    logic [IW-1:0] cid_reg, cid_next;
    logic          found_reg, found_next;
    logic          rd_pend_reg, rd_pend_next;

    logic          ovld_reg, ovld_next;
    logic [1:0]    okind_reg, okind_next;
    logic [IW-1:0] oinst_reg, oinst_next;
    logic [HW-1:0] ohd_reg, ohd_next;
    logic [GW-1:0] oarg_reg, oarg_next;
    logic          ofound_reg, ofound_next;
    logic          olast_reg, olast_next;

    logic          wr_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [EW-1:0] wr_data, rd_data;

    sdtq_slot_mem #(.DEPTH(DEPTH), .WIDTH(EW)) u_mem (
        .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
        .rd_addr(rd_addr), .rd_data(rd_data)
    );

    // Shared unit: wrap-aware distance compare of a read slot against entry
    logic [CW-1:0] dist_new, dist_slot, rd_dl, ent_dl, ent_per, sum;
    logic          new_before, slot_due, sum_late;
    assign rd_dl      = rd_data[CW-1:0];
    assign ent_dl     = ent_reg[CW-1:0];
    assign ent_per    = ent_reg[2*CW-1:CW];
    assign dist_new   = (ent_dl - now_reg) ^ {1'b1, {(CW-1){1'b0}}};
    assign dist_slot  = (rd_dl - now_reg) ^ {1'b1, {(CW-1){1'b0}}};
    assign new_before = dist_new < dist_slot;
    assign slot_due   = dist_slot <= {1'b1, {(CW-1){1'b0}}};
    assign sum        = ent_dl + ent_per;
    assign sum_late   = sum - now_reg >= {1'b1, {(CW-1){1'b0}}};

    // Walk conditions shared by the state and datapath blocks
    logic scan_end, shift_last, inst_match, count_end, emit_last;
    assign scan_end   = idx_reg >= occ_reg;
    assign shift_last = idx_reg + 1'b1 >= occ_reg;
    assign inst_match = rd_data[2*CW+HW+IW-1:2*CW+HW] == cid_reg;
    assign count_end  = (idx_reg >= occ_reg) || (due_reg >= RW'(MAX_RESULTS));
    assign emit_last  = (fired_reg + 1'b1) == due_reg;

    logic s_acc, m_acc, out_free;
    assign s_acc    = s_tvalid && s_tready;
    assign m_acc    = m_tvalid && m_tready;
    assign out_free = !ovld_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && !ovld_reg;
    assign m_tvalid = ovld_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_acc)
                begin
                    case (req_t'(s_tuser))
                        REQ_ARM:
                            state_next = (occ_reg >= NW'(DEPTH)) ? ST_OUT : ST_ARM_SCAN;
                        REQ_CANCEL:
                            state_next = ST_CAN_SCAN;
                        REQ_TICK:
                            state_next = ST_TICK_COUNT;
                        default:
                            state_next = ST_IDLE;
                    endcase
                end
            end
            ST_ARM_SCAN, ST_REINS_SCAN:
            begin
                if (scan_end || (rd_pend_reg && new_before))
                    state_next = (state_reg == ST_ARM_SCAN) ? ST_ARM_SHIFT
                                                            : ST_REINS_SHIFT;
            end
            ST_ARM_SHIFT, ST_REINS_SHIFT:
            begin
                if (idx_reg == pos_reg)
                    state_next = (state_reg == ST_ARM_SHIFT) ? ST_OUT : ST_TICK_CHECK;
            end
            ST_CAN_SCAN:
            begin
                if (scan_end)
                    state_next = ST_OUT;
                else if (rd_pend_reg && inst_match)
                    state_next = ST_CAN_SHIFT;
            end
            ST_CAN_SHIFT, ST_TICK_POP:
            begin
                if (shift_last)
                    state_next = (state_reg == ST_CAN_SHIFT) ? ST_OUT : ST_TICK_EMIT;
            end
            ST_TICK_COUNT:
            begin
                if (count_end || (rd_pend_reg && !slot_due))
                    state_next = ST_TICK_CHECK;
            end
            ST_TICK_CHECK:
            begin
                if (fired_reg >= due_reg)
                    state_next = ST_IDLE;
                else if (rd_pend_reg)
                    state_next = ST_TICK_POP;
            end
            ST_TICK_EMIT:
            begin
                if (out_free)
                    state_next = (ent_per != '0) ? ST_REINS_SCAN : ST_TICK_CHECK;
            end
            ST_OUT:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Datapath, memory control and result register
    always_comb
    begin
        now_next     = now_reg;
        occ_next     = occ_reg;
        last_next    = last_reg;
        idx_next     = idx_reg;
        pos_next     = pos_reg;
        fired_next   = fired_reg;
        due_next     = due_reg;
        ent_next     = ent_reg;
        cid_next     = cid_reg;
        found_next   = found_reg;
        rd_pend_next = 1'b0;
        ovld_next    = ovld_reg && !m_acc;
        okind_next   = okind_reg;
        oinst_next   = oinst_reg;
        ohd_next     = ohd_reg;
        oarg_next    = oarg_reg;
        ofound_next  = ofound_reg;
        olast_next   = olast_reg;
        wr_en        = 1'b0;
        wr_addr      = idx_reg[AW-1:0];
        wr_data      = ent_reg;
        rd_addr      = idx_reg[AW-1:0];
        case (state_reg)
            ST_IDLE:
            begin
                if (s_acc)
                begin
                    ent_next = pack_e(s_tdata[CW-1:0], s_tdata[2*CW-1:CW],
                        s_tdata[2*CW+HW-1:2*CW], last_reg + 1'b1,
                        s_tdata[2*CW+HW+GW-1:2*CW+HW]);
                    cid_next   = s_tdata[SIW-1:2*CW+HW+GW];
                    idx_next   = '0;
                    found_next = 1'b0;
                    fired_next = '0;
                    due_next   = '0;
                    case (req_t'(s_tuser))
                        REQ_ARM:
                        begin
                            if (occ_reg >= NW'(DEPTH))
                            begin
                                okind_next = KIND_FULL;
                                oinst_next = '0;
                            end
                            else
                            begin
                                last_next  = last_reg + 1'b1;
                                okind_next = KIND_ARMED;
                                oinst_next = last_reg + 1'b1;
                            end
                        end
                        REQ_CANCEL:
                        begin
                            okind_next = KIND_CANCEL;
                            oinst_next = s_tdata[SIW-1:2*CW+HW+GW];
                        end
                        REQ_TICK:
                            now_next = now_reg + 1'b1;
                        default:
                            now_next = now_reg;
                    endcase
                end
            end
            ST_ARM_SCAN, ST_REINS_SCAN:
            begin
                // read slot idx, compare next cycle
                if (scan_end)
                begin
                    pos_next = idx_reg;
                    idx_next = occ_reg;
                end
                else if (!rd_pend_reg)
                    rd_pend_next = 1'b1;
                else if (new_before)
                begin
                    pos_next = idx_reg;
                    idx_next = occ_reg;
                end
                else
                    idx_next = idx_reg + 1'b1;
            end
            ST_ARM_SHIFT, ST_REINS_SHIFT:
            begin
                // move slots up from the end, then write the entry
                if (idx_reg == pos_reg)
                begin
                    wr_en    = 1'b1;
                    occ_next = occ_reg + 1'b1;
                    if (state_reg == ST_REINS_SHIFT)
                        fired_next = fired_reg + 1'b1;
                end
                else
                begin
                    rd_addr = AW'(idx_reg - 1'b1);
                    if (!rd_pend_reg)
                        rd_pend_next = 1'b1;
                    else
                    begin
                        wr_en    = 1'b1;
                        wr_data  = rd_data;
                        idx_next = idx_reg - 1'b1;
                    end
                end
            end
            ST_CAN_SCAN:
            begin
                if (!scan_end)
                begin
                    if (!rd_pend_reg)
                        rd_pend_next = 1'b1;
                    else if (inst_match)
                        found_next = 1'b1;
                    else
                        idx_next = idx_reg + 1'b1;
                end
            end
            ST_CAN_SHIFT, ST_TICK_POP:
            begin
                // move slots down over idx
                if (shift_last)
                    occ_next = occ_reg - 1'b1;
                else
                begin
                    rd_addr = AW'(idx_reg + 1'b1);
                    if (!rd_pend_reg)
                        rd_pend_next = 1'b1;
                    else
                    begin
                        wr_en    = 1'b1;
                        wr_data  = rd_data;
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            ST_TICK_COUNT:
            begin
                // count the due slots at the head before any is moved
                if (!count_end)
                begin
                    if (!rd_pend_reg)
                        rd_pend_next = 1'b1;
                    else if (slot_due)
                    begin
                        due_next = due_reg + 1'b1;
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            ST_TICK_CHECK:
            begin
                // fetch the head slot while counted timers remain
                rd_addr = '0;
                if (fired_reg < due_reg)
                begin
                    if (!rd_pend_reg)
                        rd_pend_next = 1'b1;
                    else
                    begin
                        ent_next = rd_data;
                        idx_next = '0;
                    end
                end
            end
            ST_TICK_EMIT:
            begin
                if (out_free)
                begin
                    ovld_next   = 1'b1;
                    okind_next  = KIND_EXPIRY;
                    oinst_next  = ent_reg[2*CW+HW+IW-1:2*CW+HW];
                    ohd_next    = ent_reg[2*CW+HW-1:2*CW];
                    oarg_next   = ent_reg[EW-1:2*CW+HW+IW];
                    ofound_next = 1'b0;
                    olast_next  = emit_last;
                    idx_next    = '0;
                    if (ent_per != '0)
                        ent_next[CW-1:0] = sum_late ? now_reg : sum;
                    else
                        fired_next = fired_reg + 1'b1;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    ovld_next   = 1'b1;
                    ohd_next    = '0;
                    oarg_next   = '0;
                    ofound_next = found_reg;
                    olast_next  = 1'b1;
                end
            end
            default:
                rd_pend_next = 1'b0;
        endcase
    end

    // Registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            now_reg     <= '0;
            occ_reg     <= '0;
            last_reg    <= '0;
            ovld_reg    <= 1'b0;
            rd_pend_reg <= 1'b0;
            okind_reg   <= KIND_ARMED;
            olast_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            now_reg     <= now_next;
            occ_reg     <= occ_next;
            last_reg    <= last_next;
            ovld_reg    <= ovld_next;
            rd_pend_reg <= rd_pend_next;
            okind_reg   <= okind_next;
            olast_reg   <= olast_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        pos_reg    <= pos_next;
        fired_reg  <= fired_next;
        due_reg    <= due_next;
        ent_reg    <= ent_next;
        cid_reg    <= cid_next;
        found_reg  <= found_next;
        oinst_reg  <= oinst_next;
        ohd_reg    <= ohd_next;
        oarg_reg   <= oarg_next;
        ofound_reg <= ofound_next;
    end

    assign m_tdata = {{(((SOW+7)/8)*8-SOW){1'b0}}, now_reg, ofound_reg, oarg_reg,
                      ohd_reg, oinst_reg};
    assign m_tuser = okind_reg;
    assign m_tlast = olast_reg;

    `SDTQ_ASSERT(a_occ_range, clk, rst_n, occ_reg <= NW'(DEPTH), "occupancy above depth")
    `SDTQ_ASSERT(a_busy, clk, rst_n, (state_reg != ST_IDLE) |-> !s_tready, "ready while busy")
    `SDTQ_HOLD(a_out_hold, clk, rst_n, m_tvalid, m_tready, m_tdata, "result changed while stalled")
endmodule
